/* rtl/iel_pkg.sv */
// ----------------------------------------------------------------------------
// iel_pkg
// Shared types and constants of the indexed element list unit: field widths,
// stream packing, command codes and the controller-to-datapath command bundle.
// ----------------------------------------------------------------------------
package iel_pkg;

    // Storage geometry
    localparam int DEPTH  = 16;
    localparam int ADDR_W = $clog2(DEPTH);

    // Field widths
    localparam int CMD_W = 4;
    localparam int IDX_W = 5;
    localparam int VAL_W = 32;
    localparam int CNT_W = 5;

    // Stream packing, lowest bit first, padded to whole bytes
    localparam int IN_BITS    = CMD_W + IDX_W + VAL_W;
    localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = 1 + VAL_W + CNT_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        OP_PUSH_FRONT = 4'd0,
        OP_POP_FRONT  = 4'd1,
        OP_PUSH_BACK  = 4'd2,
        OP_POP_BACK   = 4'd3,
        OP_INSERT     = 4'd4,
        OP_ERASE      = 4'd5,
        OP_EXTRACT    = 4'd6,
        OP_REPLACE    = 4'd7,
        OP_READ       = 4'd8,
        OP_CLEAR      = 4'd9,
        OP_SIZE       = 4'd10
    } t_op;

    // Controller states
    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;   // capture the incoming request
        logic exec;   // run the held request and load the result register
    } t_ctl_cmd;

endpackage

/* rtl/indexed_element_list_unit.sv */
// ----------------------------------------------------------------------------
// indexed_element_list_unit
// Ordered list of up to 16 elements of 32 bits with push and pop at both
// ends and insert, erase, extract, replace and read at an index.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_axis channel: tdata holds cmd, index and
//   write_value. Each request gives exactly one result on the m_axis
//   channel: tdata holds ok, read_value and count after the command.
//   A request is captured into the request register at the edge that
//   accepts it and executed once the output register is free, when the
//   whole storage shifts by one place in parallel; the result is loaded
//   into the output register by execution and stays there until taken.
//   While a request executes the next one can be accepted, so the block
//   sustains one request per cycle as long as the receiver keeps tready
//   high. When the receiver stalls, one more request is taken into the
//   request register, after which s_axis tready stays low until the
//   pending result is taken.
//   Synchronous reset empties the list and drops any pending result;
//   the element storage itself keeps its contents and needs no clearing.
// ----------------------------------------------------------------------------
module indexed_element_list_unit
    import iel_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // [3:0] cmd, [8:4] index, [40:9] write_value, rest zero
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [0] ok, [32:1] read_value, [37:33] count, rest zero
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    t_ctl_cmd w_cmd;

    iel_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    iel_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_in_data  (i_s_axis_tdata),
        .o_out_data (o_m_axis_tdata)
    );

endmodule

/* rtl/iel_ctrl.sv */
// ----------------------------------------------------------------------------
// iel_ctrl
// Controller of the indexed element list: request acceptance, execution
// timing and the result valid flag.
// ----------------------------------------------------------------------------
module iel_ctrl
    import iel_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_out_ready,
    output logic     o_in_ready,
    output logic     o_out_valid,
    output t_ctl_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_slot_free;
    logic   w_accept;

    assign w_slot_free = !r_out_valid || i_out_ready;

    // Outputs: take a request when idle, or while the held one executes
    always_comb begin
        o_cmd.exec = 1'b0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            ST_EXEC: begin
                o_cmd.exec = w_slot_free;
                o_in_ready = w_slot_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
        w_accept   = o_in_ready && i_in_valid;
        o_cmd.load = w_accept;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (w_accept) begin
                    n_state = ST_EXEC;
                end else if (w_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Result flag: set on execution, drop once taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.exec) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    // Checks
    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_EXEC))
        else $error("accepted request did not reach execution");

    a_exec_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> r_out_valid)
        else $error("execution did not present a result");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC && r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("request taken while result slot blocked");

endmodule

/* rtl/iel_datapath.sv */
// ----------------------------------------------------------------------------
// iel_datapath
// Datapath of the indexed element list: request register, element storage
// with parallel neighbour shifts, element count and result register.
// ----------------------------------------------------------------------------
module iel_datapath
    import iel_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_ctl_cmd              i_cmd,
    input  logic [IN_DATA_W-1:0]  i_in_data,
    output logic [OUT_DATA_W-1:0] o_out_data
);

    // Held request
    t_op              r_op;
    logic [IDX_W-1:0] r_idx;
    logic [VAL_W-1:0] r_wv;

    // Storage and count
    logic [VAL_W-1:0] r_entries [DEPTH];
    logic [VAL_W-1:0] n_entries [DEPTH];
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    // Result register
    logic             r_ok;
    logic [VAL_W-1:0] r_rv;
    logic             n_ok;
    logic [VAL_W-1:0] n_rv;

    // Decode
    logic             w_full;
    logic             w_empty;
    logic             w_idx_in;
    logic             w_open;
    logic             w_close;
    logic             w_write;
    logic             w_rd;
    logic [CNT_W-1:0] w_pos;

    // Capture request
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= t_op'(i_in_data[CMD_W-1:0]);
            r_idx <= i_in_data[CMD_W +: IDX_W];
            r_wv  <= i_in_data[CMD_W+IDX_W +: VAL_W];
        end
    end

    // Decode the held request against the current count
    always_comb begin
        w_full   = (r_count == CNT_W'(DEPTH));
        w_empty  = (r_count == '0);
        w_idx_in = (r_idx < r_count);
        w_open   = 1'b0;
        w_close  = 1'b0;
        w_write  = 1'b0;
        w_rd     = 1'b0;
        w_pos    = r_idx;
        n_ok     = 1'b0;
        n_count  = r_count;
        unique case (r_op)
            OP_PUSH_FRONT: begin
                w_pos = '0;
                if (!w_full) begin
                    w_open  = 1'b1;
                    w_write = 1'b1;
                    n_count = r_count + 1'b1;
                    n_ok    = 1'b1;
                end
            end
            OP_POP_FRONT: begin
                w_pos = '0;
                if (!w_empty) begin
                    w_rd    = 1'b1;
                    w_close = 1'b1;
                    n_count = r_count - 1'b1;
                    n_ok    = 1'b1;
                end
            end
            OP_PUSH_BACK: begin
                w_pos = r_count;
                if (!w_full) begin
                    w_write = 1'b1;
                    n_count = r_count + 1'b1;
                    n_ok    = 1'b1;
                end
            end
            OP_POP_BACK: begin
                w_pos = r_count - 1'b1;
                if (!w_empty) begin
                    w_rd    = 1'b1;
                    n_count = r_count - 1'b1;
                    n_ok    = 1'b1;
                end
            end
            OP_INSERT: begin
                if (!w_full && r_idx <= r_count) begin
                    w_open  = 1'b1;
                    w_write = 1'b1;
                    n_count = r_count + 1'b1;
                    n_ok    = 1'b1;
                end
            end
            OP_ERASE: begin
                if (w_idx_in) begin
                    w_close = 1'b1;
                    n_count = r_count - 1'b1;
                    n_ok    = 1'b1;
                end
            end
            OP_EXTRACT: begin
                if (w_idx_in) begin
                    w_rd    = 1'b1;
                    w_close = 1'b1;
                    n_count = r_count - 1'b1;
                    n_ok    = 1'b1;
                end
            end
            OP_REPLACE: begin
                if (w_idx_in) begin
                    w_write = 1'b1;
                    n_ok    = 1'b1;
                end
            end
            OP_READ: begin
                if (w_idx_in) begin
                    w_rd = 1'b1;
                    n_ok = 1'b1;
                end
            end
            OP_CLEAR: begin
                n_count = '0;
                n_ok    = 1'b1;
            end
            OP_SIZE: begin
                n_ok = 1'b1;
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    // Read the selected element; zero unless the request returns one
    always_comb begin
        n_rv = '0;
        if (w_rd) begin
            n_rv = r_entries[w_pos[ADDR_W-1:0]];
        end
    end

    // Next value of each entry: hold, shift up, shift down or write
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_entries[i] = r_entries[i];
            if (w_open && CNT_W'(i) > w_pos) begin
                n_entries[i] = r_entries[(i > 0) ? i - 1 : i];
            end else if (w_close && CNT_W'(i) >= w_pos) begin
                n_entries[i] = r_entries[(i < DEPTH - 1) ? i + 1 : i];
            end else if (w_write && CNT_W'(i) == w_pos) begin
                n_entries[i] = r_wv;
            end
        end
    end

    // Storage and result update
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_entries[i] <= n_entries[i];
            end
            r_ok <= n_ok;
            r_rv <= n_rv;
        end
    end

    // Count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    // Pack result: ok, read_value, count
    assign o_out_data = {{(OUT_DATA_W - OUT_BITS){1'b0}}, r_count, r_rv, r_ok};

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("element count beyond capacity");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && r_op != OP_CLEAR) |=>
        (r_count == $past(r_count) || r_count == $past(r_count) + 1'b1 ||
         r_count == $past(r_count) - 1'b1))
        else $error("count moved by more than one element");

endmodule

/* tb/sv/indexed_element_list_unit_tb.sv */
// ----------------------------------------------------------------------------
// indexed_element_list_unit_tb
// Self-checking bench for the indexed element list unit. A directed table
// covers the empty list, the full list, rejected indexes, reserved commands
// and clearing, then random request streams drive the list up to full and
// back down to empty under several idle and stall patterns, including one
// long hold-off on the result side. Every result is compared with a local
// model of the list, or with the expected values given in the table.
// ----------------------------------------------------------------------------
module indexed_element_list_unit_tb;
    import iel_pkg::*;

    localparam int CYCLE_LIMIT     = 200_000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 10;
    localparam int PHASE_ITEMS     = 260;
    localparam int PRESSURE_ITEMS  = 60;
    localparam int SWEEP_LEN       = 60;
    localparam int MAX_REPORTS     = 10;
    localparam int N_DIRECTED      = 28;

    // Command codes outside the defined set
    localparam logic [CMD_W-1:0] CMD_RESERVED_BASE = 4'd11;
    localparam logic [CMD_W-1:0] CMD_RESERVED_TOP  = 4'd15;

    // Request and result layouts, lowest field in the lowest bits
    typedef struct packed {
        logic [VAL_W-1:0] wv;
        logic [IDX_W-1:0] idx;
        logic [CMD_W-1:0] cmd;
    } t_list_req;

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [VAL_W-1:0] rv;
        logic             ok;
    } t_list_result;

    typedef struct {
        logic [CMD_W-1:0] cmd;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] wv;
        int               rpt;
        bit               known;
        logic             e_ok;
        logic [VAL_W-1:0] e_rv;
        logic [CNT_W-1:0] e_cnt;
    } t_directed_row;

    logic                  i_clk;
    logic                  i_rst_n         = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    // [3:0] cmd, [8:4] index, [40:9] write_value, rest zero
    logic [IN_DATA_W-1:0]  i_s_axis_tdata  = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    // [0] ok, [32:1] read_value, [37:33] count, rest zero
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;

    // Model of the list contents
    logic [VAL_W-1:0] list_mem [DEPTH];
    int               list_len = 0;

    t_list_result  pending_results [$];
    t_directed_row directed_rows [N_DIRECTED];

    int  tx_idle_pct  = 0;
    int  rx_stall_pct = 0;
    bit  hold_off_req = 1'b0;
    int  fail_count   = 0;
    int  cycle_count  = 0;
    bit  growing      = 1'b0;
    int  picks_made   = 0;

    t_list_result got_result;
    t_list_result want_result;

    indexed_element_list_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Apply one command to the model list and return the result it gives
    function automatic t_list_result apply_to_list(input t_list_req req);
        t_list_result res;
        int           pos;
        res = '0;
        case (req.cmd)
            OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT: begin
                pos = (req.cmd == OP_PUSH_FRONT) ? 0 :
                      (req.cmd == OP_PUSH_BACK)  ? list_len : int'(req.idx);
                if (list_len < DEPTH && pos <= list_len) begin
                    for (int i = list_len; i > pos; i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[pos] = req.wv;
                    list_len++;
                    res.ok = 1'b1;
                end
            end
            OP_POP_FRONT, OP_POP_BACK, OP_ERASE, OP_EXTRACT: begin
                pos = (req.cmd == OP_POP_FRONT) ? 0 :
                      (req.cmd == OP_POP_BACK)  ? list_len - 1 : int'(req.idx);
                if (list_len > 0 && pos < list_len) begin
                    if (req.cmd != OP_ERASE)
                        res.rv = list_mem[pos];
                    for (int i = pos; i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i+1];
                    list_len--;
                    res.ok = 1'b1;
                end
            end
            OP_REPLACE: begin
                if (int'(req.idx) < list_len) begin
                    list_mem[req.idx] = req.wv;
                    res.ok = 1'b1;
                end
            end
            OP_READ: begin
                if (int'(req.idx) < list_len) begin
                    res.rv = list_mem[req.idx];
                    res.ok = 1'b1;
                end
            end
            OP_CLEAR: begin
                list_len = 0;
                res.ok   = 1'b1;
            end
            OP_SIZE: res.ok = 1'b1;
            default: ;
        endcase
        res.cnt = CNT_W'(list_len);
        return res;
    endfunction

    // Pick a random request, biased so the list sweeps between empty and full
    function automatic t_list_req pick_request(input bit grow);
        t_list_req req;
        int        roll;
        bit        adds;
        roll = $urandom_range(99);
        case ($urandom_range(7))
            0:       req.wv = '0;
            1:       req.wv = '1;
            2:       req.wv = 32'h1 << $urandom_range(31);
            3:       req.wv = ~(32'h1 << $urandom_range(31));
            default: req.wv = $urandom;
        endcase
        if (roll < 60) begin
            adds = (roll < 45) ? grow : !grow;
            if (adds) begin
                case ($urandom_range(2))
                    0:       req.cmd = OP_PUSH_FRONT;
                    1:       req.cmd = OP_PUSH_BACK;
                    default: req.cmd = OP_INSERT;
                endcase
            end else begin
                case ($urandom_range(3))
                    0:       req.cmd = OP_POP_FRONT;
                    1:       req.cmd = OP_POP_BACK;
                    2:       req.cmd = OP_ERASE;
                    default: req.cmd = OP_EXTRACT;
                endcase
            end
        end else if (roll < 75) begin
            req.cmd = OP_READ;
        end else if (roll < 86) begin
            req.cmd = OP_REPLACE;
        end else if (roll < 91) begin
            req.cmd = OP_SIZE;
        end else if (roll < 92) begin
            req.cmd = OP_CLEAR;
        end else if (roll < 95) begin
            req.cmd = CMD_W'($urandom_range(CMD_RESERVED_TOP, CMD_RESERVED_BASE));
        end else begin
            req.cmd = CMD_W'($urandom_range(CMD_RESERVED_TOP));
        end
        // Mostly legal positions, now and then anything the field holds
        if ($urandom_range(9) < 8) begin
            if (req.cmd == OP_INSERT)
                req.idx = IDX_W'($urandom_range(list_len));
            else
                req.idx = (list_len > 0) ? IDX_W'($urandom_range(list_len - 1)) : '0;
        end else begin
            req.idx = IDX_W'($urandom_range(31));
        end
        return req;
    endfunction

    // Offer one request, with random idle cycles first; return once accepted
    task automatic send_request(input t_list_req req);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= IN_DATA_W'(req);
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
    endtask

    task automatic run_random(input int n_items);
        t_list_req req;
        for (int n = 0; n < n_items; n++) begin
            if (picks_made % SWEEP_LEN == 0)
                growing = !growing;
            picks_made++;
            req = pick_request(growing);
            send_request(req);
            pending_results.insert(pending_results.size(), apply_to_list(req));
        end
    endtask

    task automatic note_mismatch(input string what);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("[%0d] %s", cycle_count, what);
    endtask

    // Result side: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end
            i_m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got_result = t_list_result'(o_m_axis_tdata[OUT_BITS-1:0]);
            if (pending_results.size() == 0) begin
                note_mismatch($sformatf("result with nothing pending: ok=%0d rv=%h cnt=%0d",
                                        got_result.ok, got_result.rv, got_result.cnt));
            end else begin
                want_result = pending_results[0];
                pending_results.delete(0);
                if (got_result.ok !== want_result.ok || got_result.rv !== want_result.rv ||
                    got_result.cnt !== want_result.cnt)
                    note_mismatch($sformatf(
                        "mismatch: exp ok=%0d rv=%h cnt=%0d, got ok=%0d rv=%h cnt=%0d",
                        want_result.ok, want_result.rv, want_result.cnt,
                        got_result.ok, got_result.rv, got_result.cnt));
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        t_list_req    req;
        t_list_result want;

        directed_rows = '{
            // empty list: every removal and index access is rejected
            '{OP_SIZE,          5'd0,  32'h0,        1,  1'b1, 1'b1, 32'h0, 5'd0},
            '{OP_POP_FRONT,     5'd0,  32'h0,        1,  1'b1, 1'b0, 32'h0, 5'd0},
            '{OP_POP_BACK,      5'd0,  32'h0,        1,  1'b1, 1'b0, 32'h0, 5'd0},
            '{OP_READ,          5'd0,  32'h0,        1,  1'b1, 1'b0, 32'h0, 5'd0},
            '{OP_ERASE,         5'd0,  32'h0,        1,  1'b1, 1'b0, 32'h0, 5'd0},
            '{OP_EXTRACT,       5'd0,  32'h0,        1,  1'b1, 1'b0, 32'h0, 5'd0},
            '{OP_REPLACE,       5'd0,  32'hFFFFFFFF, 1,  1'b1, 1'b0, 32'h0, 5'd0},
            '{OP_INSERT,        5'd1,  32'hDEADBEEF, 1,  1'b1, 1'b0, 32'h0, 5'd0},
            '{CMD_RESERVED_TOP, 5'd31, 32'hFFFFFFFF, 1,  1'b1, 1'b0, 32'h0, 5'd0},
            // build a short list at both ends and in the middle
            '{OP_PUSH_BACK,     5'd0,  32'hFFFFFFFF, 1,  1'b1, 1'b1, 32'h0, 5'd1},
            '{OP_PUSH_FRONT,    5'd0,  32'h0,        1,  1'b1, 1'b1, 32'h0, 5'd2},
            '{OP_INSERT,        5'd2,  32'hA5A5A5A5, 1,  1'b1, 1'b1, 32'h0, 5'd3},
            '{OP_INSERT,        5'd1,  32'h5A5A5A5A, 1,  1'b0, 1'b0, 32'h0, 5'd0},
            '{OP_READ,          5'd3,  32'h0,        1,  1'b0, 1'b0, 32'h0, 5'd0},
            '{OP_REPLACE,       5'd0,  32'h00000001, 1,  1'b0, 1'b0, 32'h0, 5'd0},
            '{OP_EXTRACT,       5'd1,  32'h0,        1,  1'b0, 1'b0, 32'h0, 5'd0},
            '{OP_ERASE,         5'd0,  32'h0,        1,  1'b0, 1'b0, 32'h0, 5'd0},
            '{OP_READ,          5'd31, 32'h0,        1,  1'b0, 1'b0, 32'h0, 5'd0},
            '{OP_POP_BACK,      5'd0,  32'h0,        1,  1'b0, 1'b0, 32'h0, 5'd0},
            // fill up, then hit the full list from every side
            '{OP_PUSH_BACK,     5'd0,  32'h80000000, 15, 1'b0, 1'b0, 32'h0, 5'd0},
            '{OP_PUSH_FRONT,    5'd0,  32'h12345678, 1,  1'b0, 1'b0, 32'h0, 5'd0},
            '{OP_INSERT,        5'd16, 32'h12345678, 1,  1'b0, 1'b0, 32'h0, 5'd0},
            '{OP_READ,          5'd15, 32'h0,        1,  1'b0, 1'b0, 32'h0, 5'd0},
            '{OP_POP_FRONT,     5'd0,  32'h0,        1,  1'b0, 1'b0, 32'h0, 5'd0},
            '{OP_INSERT,        5'd15, 32'hC3C3C3C3, 1,  1'b0, 1'b0, 32'h0, 5'd0},
            '{OP_EXTRACT,       5'd15, 32'h0,        1,  1'b0, 1'b0, 32'h0, 5'd0},
            // clear a nearly full list, then an empty one
            '{OP_CLEAR,         5'd0,  32'h0,        1,  1'b1, 1'b1, 32'h0, 5'd0},
            '{OP_CLEAR,         5'd0,  32'h0,        1,  1'b1, 1'b1, 32'h0, 5'd0}
        };

        // Hold reset, then release it
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        foreach (directed_rows[r]) begin
            for (int k = 0; k < directed_rows[r].rpt; k++) begin
                req.cmd = directed_rows[r].cmd;
                req.idx = directed_rows[r].idx;
                req.wv  = directed_rows[r].wv + VAL_W'(k);
                send_request(req);
                want = apply_to_list(req);
                if (directed_rows[r].known) begin
                    want.ok  = directed_rows[r].e_ok;
                    want.rv  = directed_rows[r].e_rv;
                    want.cnt = directed_rows[r].e_cnt;
                end
                pending_results.insert(pending_results.size(), want);
            end
        end

        // Random streams under each idle pattern
        tx_idle_pct = 0;  rx_stall_pct = 0;
        run_random(PHASE_ITEMS);
        tx_idle_pct = 56; rx_stall_pct = 0;
        run_random(PHASE_ITEMS);

        // Long hold-off on the result side while requests keep coming
        tx_idle_pct  = 0;
        hold_off_req = 1'b1;
        run_random(PRESSURE_ITEMS);

        tx_idle_pct = 0;  rx_stall_pct = 56;
        run_random(PHASE_ITEMS);
        tx_idle_pct = 10; rx_stall_pct = 10;
        run_random(PHASE_ITEMS);

        // Drain
        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
